// ===== hw/rtl/owtsm_pkg.sv =====
// Shared types, codes and constants for the one-wire temperature sensor master.
// Holds the CRC-8 update function used by the sequencing logic.
// No dependencies.
package owtsm_pkg;

    // Command kinds carried with each tick item
    localparam logic [1:0] REQ_NONE    = 2'd0;
    localparam logic [1:0] REQ_CONVERT = 2'd1;
    localparam logic [1:0] REQ_SET_RES = 2'd2;
    localparam logic [1:0] REQ_READ    = 2'd3;

    // Sequence step codes
    localparam logic [3:0] STEP_IDLE     = 4'd0;
    localparam logic [3:0] STEP_RST_LOW  = 4'd1;
    localparam logic [3:0] STEP_RST_WAIT = 4'd2;
    localparam logic [3:0] STEP_WRITE    = 4'd3;
    localparam logic [3:0] STEP_READ     = 4'd4;

    // Slot phase codes
    localparam logic [2:0] PHASE_OPEN = 3'd0;
    localparam logic [2:0] PHASE_MID  = 3'd1;
    localparam logic [2:0] PHASE_TAIL = 3'd2;

    // Configuration register indexes
    localparam logic [2:0] CFG_RESET_TICKS   = 3'd0;
    localparam logic [2:0] CFG_START_TICKS   = 3'd1;
    localparam logic [2:0] CFG_WRITE_SLOT    = 3'd2;
    localparam logic [2:0] CFG_READ_SAMPLE   = 3'd3;
    localparam logic [2:0] CFG_READ_TAIL     = 3'd4;
    localparam logic [2:0] CFG_ALARM_HIGH    = 3'd5;
    localparam logic [2:0] CFG_ALARM_LOW     = 3'd6;
    localparam logic [2:0] CFG_RESOLUTION    = 3'd7;

    // Configuration reset values
    localparam logic [9:0] RST_RESET_TICKS = 10'd400;
    localparam logic [3:0] RST_START_TICKS = 4'd2;
    localparam logic [7:0] RST_WRITE_SLOT  = 8'd60;
    localparam logic [5:0] RST_READ_SAMPLE = 6'd6;
    localparam logic [7:0] RST_READ_TAIL   = 8'd80;
    localparam logic [7:0] RST_RESOLUTION  = 8'h1F;

    // ROM command bytes
    localparam logic [7:0] ROM_SKIP       = 8'hCC;
    localparam logic [7:0] FN_CONVERT     = 8'h44;
    localparam logic [7:0] FN_WRITE_PAD   = 8'h4E;
    localparam logic [7:0] FN_READ_PAD    = 8'hBE;
    localparam logic [7:0] CRC_POLY       = 8'h18;

    // Bytes written per command
    localparam logic [3:0] WR_COUNT_SET_RES = 4'd5;
    localparam logic [3:0] WR_COUNT_SHORT   = 4'd2;

    localparam int CFG_DATA_W = 10;

    typedef struct packed {
        logic [9:0] reset_ticks;
        logic [3:0] start_ticks;
        logic [7:0] write_slot_ticks;
        logic [5:0] read_sample_ticks;
        logic [7:0] read_tail_ticks;
        logic [7:0] alarm_high_byte;
        logic [7:0] alarm_low_byte;
        logic [7:0] resolution_byte;
    } owtsm_cfg_t;

    typedef struct packed {
        logic [3:0]  step;
        logic [1:0]  cmd;
        logic [2:0]  phase;
        logic [9:0]  cnt;
        logic [2:0]  bit_idx;
        logic [3:0]  byte_idx;
        logic [7:0]  shift;
        logic [7:0]  crc;
        logic [7:0]  low_byte;
        logic [7:0]  high_byte;
        logic [15:0] temp;
        logic        crc_ok;
    } owtsm_state_t;

    // Result fields, lowest bit last
    typedef struct packed {
        logic               rejected;
        logic               crc_ok;
        logic signed [15:0] temperature;
        logic               done_res;
        logic               busy_res;
        logic               drive_low;
    } owtsm_res_t;

    // Reflected CRC-8 over one byte, least-significant bit first
    function automatic logic [7:0] crc8_update(input logic [7:0] c_in, input logic [7:0] d_in);
        logic [7:0] c;
        logic [7:0] d;
        logic       fb;
        c = c_in;
        d = d_in;
        for (int k = 0; k < 8; k++)
        begin
            fb = c[0] ^ d[0];
            if (fb)
            begin
                c = c ^ CRC_POLY;
            end
            c = {fb, c[7:1]};
            d = {1'b0, d[7:1]};
        end
        return c;
    endfunction

endpackage

// ===== hw/rtl/owtsm_cfg.sv =====
// Configuration register file for the one-wire temperature sensor master.
// Depends on owtsm_pkg for the register record and index codes.
module owtsm_cfg
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_we,
    input  logic [2:0]                           cfg_addr,
    input  logic [owtsm_pkg::CFG_DATA_W-1:0]     cfg_data,
    output owtsm_pkg::owtsm_cfg_t                cfg
);

    owtsm_pkg::owtsm_cfg_t cfg_reg;
    owtsm_pkg::owtsm_cfg_t cfg_next;

    // Decode the write into the addressed register
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            unique case (cfg_addr)
                owtsm_pkg::CFG_RESET_TICKS: cfg_next.reset_ticks       = cfg_data[9:0];
                owtsm_pkg::CFG_START_TICKS: cfg_next.start_ticks       = cfg_data[3:0];
                owtsm_pkg::CFG_WRITE_SLOT:  cfg_next.write_slot_ticks  = cfg_data[7:0];
                owtsm_pkg::CFG_READ_SAMPLE: cfg_next.read_sample_ticks = cfg_data[5:0];
                owtsm_pkg::CFG_READ_TAIL:   cfg_next.read_tail_ticks   = cfg_data[7:0];
                owtsm_pkg::CFG_ALARM_HIGH:  cfg_next.alarm_high_byte   = cfg_data[7:0];
                owtsm_pkg::CFG_ALARM_LOW:   cfg_next.alarm_low_byte    = cfg_data[7:0];
                owtsm_pkg::CFG_RESOLUTION:  cfg_next.resolution_byte   = cfg_data[7:0];
            endcase
        end
    end

    // Hold register values, load defaults on reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.reset_ticks       <= owtsm_pkg::RST_RESET_TICKS;
            cfg_reg.start_ticks       <= owtsm_pkg::RST_START_TICKS;
            cfg_reg.write_slot_ticks  <= owtsm_pkg::RST_WRITE_SLOT;
            cfg_reg.read_sample_ticks <= owtsm_pkg::RST_READ_SAMPLE;
            cfg_reg.read_tail_ticks   <= owtsm_pkg::RST_READ_TAIL;
            cfg_reg.alarm_high_byte   <= 8'd0;
            cfg_reg.alarm_low_byte    <= 8'd0;
            cfg_reg.resolution_byte   <= owtsm_pkg::RST_RESOLUTION;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

// ===== hw/rtl/owtsm_step.sv =====
// Combinational tick step of the one-wire sequencer: next state and result fields.
// Depends on owtsm_pkg for state, config and result records and the CRC function.
module owtsm_step
#(
    parameter int SCRATCHPAD_BYTES = 9
)
(
    input  owtsm_pkg::owtsm_state_t st,
    input  owtsm_pkg::owtsm_cfg_t   cfg,
    input  logic [1:0]              req_type,
    input  logic                    line_level,
    output owtsm_pkg::owtsm_state_t st_next,
    output owtsm_pkg::owtsm_res_t   res
);

    localparam logic [3:0] LAST_BYTE = 4'(SCRATCHPAD_BYTES - 1);

    owtsm_pkg::owtsm_state_t n;
    logic [9:0] len_raw;
    logic [9:0] len_eff;
    logic [9:0] cnt_inc;
    logic       over;
    logic       drive;
    logic       done;
    logic       rej;
    logic [3:0] wr_count;

    // Byte to send for a given position of the write phase
    function automatic logic [7:0] wr_byte(input logic [3:0] idx, input logic [1:0] cmd,
                                           input owtsm_pkg::owtsm_cfg_t c);
        logic [7:0] b;
        unique case (idx)
            4'd0: b = owtsm_pkg::ROM_SKIP;
            4'd1:
            begin
                if (cmd == owtsm_pkg::REQ_CONVERT)
                begin
                    b = owtsm_pkg::FN_CONVERT;
                end
                else if (cmd == owtsm_pkg::REQ_SET_RES)
                begin
                    b = owtsm_pkg::FN_WRITE_PAD;
                end
                else
                begin
                    b = owtsm_pkg::FN_READ_PAD;
                end
            end
            4'd2:    b = c.alarm_high_byte;
            4'd3:    b = c.alarm_low_byte;
            default: b = c.resolution_byte;
        endcase
        return b;
    endfunction

    always_comb
    begin
        n     = st;
        drive = 1'b0;
        done  = 1'b0;
        rej   = 1'b0;

        // Start a command when idle, flag it when busy
        if (req_type != owtsm_pkg::REQ_NONE)
        begin
            if (n.step != owtsm_pkg::STEP_IDLE)
            begin
                rej = 1'b1;
            end
            else
            begin
                n.cmd      = req_type;
                n.step     = owtsm_pkg::STEP_RST_LOW;
                n.phase    = owtsm_pkg::PHASE_OPEN;
                n.cnt      = 10'd0;
                n.bit_idx  = 3'd0;
                n.byte_idx = 4'd0;
                n.shift    = 8'd0;
                n.crc      = 8'd0;
            end
        end

        // Pick the length of the current timing phase
        unique case (n.step)
            owtsm_pkg::STEP_RST_LOW, owtsm_pkg::STEP_RST_WAIT:
                len_raw = cfg.reset_ticks;
            owtsm_pkg::STEP_WRITE:
            begin
                if (n.phase == owtsm_pkg::PHASE_MID)
                begin
                    len_raw = {2'b00, cfg.write_slot_ticks};
                end
                else
                begin
                    len_raw = {6'd0, cfg.start_ticks};
                end
            end
            owtsm_pkg::STEP_READ:
            begin
                if (n.phase == owtsm_pkg::PHASE_OPEN)
                begin
                    len_raw = {6'd0, cfg.start_ticks};
                end
                else if (n.phase == owtsm_pkg::PHASE_MID)
                begin
                    len_raw = {4'd0, cfg.read_sample_ticks};
                end
                else
                begin
                    len_raw = {2'b00, cfg.read_tail_ticks};
                end
            end
            default: len_raw = 10'd0;
        endcase

        // Advance the tick counter; a zero length lasts one tick
        len_eff  = (len_raw == 10'd0) ? 10'd1 : len_raw;
        cnt_inc  = n.cnt + 10'd1;
        over     = (cnt_inc >= len_eff);
        wr_count = (n.cmd == owtsm_pkg::REQ_SET_RES) ? owtsm_pkg::WR_COUNT_SET_RES
                                                      : owtsm_pkg::WR_COUNT_SHORT;

        unique case (n.step)
            owtsm_pkg::STEP_IDLE:
            begin
            end
            owtsm_pkg::STEP_RST_LOW:
            begin
                drive = 1'b1;
                n.cnt = over ? 10'd0 : cnt_inc;
                if (over)
                begin
                    n.step = owtsm_pkg::STEP_RST_WAIT;
                end
            end
            owtsm_pkg::STEP_RST_WAIT:
            begin
                n.cnt = over ? 10'd0 : cnt_inc;
                if (over)
                begin
                    n.step     = owtsm_pkg::STEP_WRITE;
                    n.phase    = owtsm_pkg::PHASE_OPEN;
                    n.bit_idx  = 3'd0;
                    n.byte_idx = 4'd0;
                    n.shift    = wr_byte(4'd0, n.cmd, cfg);
                end
            end
            owtsm_pkg::STEP_WRITE:
            begin
                n.cnt = over ? 10'd0 : cnt_inc;
                if (n.phase == owtsm_pkg::PHASE_OPEN)
                begin
                    drive = 1'b1;
                    if (over)
                    begin
                        n.phase = owtsm_pkg::PHASE_MID;
                    end
                end
                else if (n.phase == owtsm_pkg::PHASE_MID)
                begin
                    drive = ~n.shift[0];
                    if (over)
                    begin
                        n.phase = owtsm_pkg::PHASE_TAIL;
                    end
                end
                else if (over)
                begin
                    // Recovery done: shift out the next bit or byte, or end the write step
                    n.phase = owtsm_pkg::PHASE_OPEN;
                    n.shift = {1'b0, n.shift[7:1]};
                    if (n.bit_idx != 3'd7)
                    begin
                        n.bit_idx = n.bit_idx + 3'd1;
                    end
                    else
                    begin
                        n.bit_idx  = 3'd0;
                        n.byte_idx = n.byte_idx + 4'd1;
                        if (n.byte_idx >= wr_count)
                        begin
                            if (n.cmd == owtsm_pkg::REQ_READ)
                            begin
                                n.step     = owtsm_pkg::STEP_READ;
                                n.byte_idx = 4'd0;
                                n.shift    = 8'd0;
                                n.crc      = 8'd0;
                            end
                            else
                            begin
                                n.step     = owtsm_pkg::STEP_IDLE;
                                n.phase    = owtsm_pkg::PHASE_OPEN;
                                n.cnt      = 10'd0;
                                n.bit_idx  = 3'd0;
                                n.byte_idx = 4'd0;
                                done       = 1'b1;
                            end
                        end
                        else
                        begin
                            n.shift = wr_byte(n.byte_idx, n.cmd, cfg);
                        end
                    end
                end
            end
            owtsm_pkg::STEP_READ:
            begin
                n.cnt = over ? 10'd0 : cnt_inc;
                if (n.phase == owtsm_pkg::PHASE_OPEN)
                begin
                    drive = 1'b1;
                    if (over)
                    begin
                        n.phase = owtsm_pkg::PHASE_MID;
                    end
                end
                else if (n.phase == owtsm_pkg::PHASE_MID)
                begin
                    // Sample the line into the top of the shift byte
                    if (over)
                    begin
                        n.shift = {line_level, n.shift[7:1]};
                        n.phase = owtsm_pkg::PHASE_TAIL;
                    end
                end
                else if (over)
                begin
                    n.phase = owtsm_pkg::PHASE_OPEN;
                    if (n.bit_idx != 3'd7)
                    begin
                        n.bit_idx = n.bit_idx + 3'd1;
                    end
                    else
                    begin
                        // Byte complete: fold into CRC and keep the temperature bytes
                        n.bit_idx = 3'd0;
                        n.crc     = owtsm_pkg::crc8_update(n.crc, n.shift);
                        if (n.byte_idx == 4'd0)
                        begin
                            n.low_byte = n.shift;
                        end
                        if (n.byte_idx == 4'd1)
                        begin
                            n.high_byte = n.shift;
                        end
                        if (n.byte_idx >= LAST_BYTE)
                        begin
                            if (n.crc == 8'd0)
                            begin
                                n.temp   = {n.high_byte, n.low_byte};
                                n.crc_ok = 1'b1;
                            end
                            else
                            begin
                                n.temp   = 16'd0;
                                n.crc_ok = 1'b0;
                            end
                            n.step     = owtsm_pkg::STEP_IDLE;
                            n.phase    = owtsm_pkg::PHASE_OPEN;
                            n.cnt      = 10'd0;
                            n.bit_idx  = 3'd0;
                            n.byte_idx = 4'd0;
                            done       = 1'b1;
                        end
                        else
                        begin
                            n.byte_idx = n.byte_idx + 4'd1;
                            n.shift    = 8'd0;
                        end
                    end
                end
            end
            default:
            begin
                // Unknown step: drop back to idle
                n.step     = owtsm_pkg::STEP_IDLE;
                n.phase    = owtsm_pkg::PHASE_OPEN;
                n.cnt      = 10'd0;
                n.bit_idx  = 3'd0;
                n.byte_idx = 4'd0;
            end
        endcase

        res.drive_low   = drive;
        res.busy_res    = (n.step != owtsm_pkg::STEP_IDLE);
        res.done_res    = done;
        res.temperature = n.temp;
        res.crc_ok      = n.crc_ok;
        res.rejected    = rej;
    end

    assign st_next = n;

endmodule

// ===== hw/rtl/one_wire_temp_sensor_master_top.sv =====
// One-wire temperature sensor master: stream ports, input and result registers, state.
// Depends on owtsm_pkg, owtsm_cfg and owtsm_step.
//
// Each item is one microsecond tick of bus time carrying the sampled line level and an
// optional command; every item gives exactly one result item with the line drive, busy,
// done, temperature, crc_ok and rejected fields. One item is taken every clock cycle while
// the result side is not stalled: an item is held in the input register, passes through a
// single combinational step of the sequencer, and its result lands in the output register.
// The output register parts the two sides, and the input register refills in the same
// cycle that the output is taken, so a stall on the result side only holds the stream for
// as long as it lasts.
// Configuration writes take effect at once; write them while the sequencer is idle.
module one_wire_temp_sensor_master_top
#(
    parameter int SCRATCHPAD_BYTES = 9
)
(
    input  logic                             clk,
    input  logic                             rst_n,
    // Input stream
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [7:0]                       s_tdata,  // [0] line_level, [7:1] zero
    input  logic [1:0]                       s_tuser,  // [1:0] req_type
    // Result stream
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // [0] drive_low, [1] busy_res, [2] done_res, [18:3] temperature,
    // [19] crc_ok, [20] rejected, [23:21] zero
    output logic [23:0]                      m_tdata,
    // Configuration port
    input  logic                             cfg_we,
    input  logic [2:0]                       cfg_addr,
    input  logic [owtsm_pkg::CFG_DATA_W-1:0] cfg_data
);

    owtsm_pkg::owtsm_cfg_t   cfg;
    owtsm_pkg::owtsm_state_t state_reg;
    owtsm_pkg::owtsm_state_t state_next;
    owtsm_pkg::owtsm_res_t   step_res;
    owtsm_pkg::owtsm_res_t   out_res_reg;

    logic       in_valid_reg;
    logic [1:0] in_req_reg;
    logic       in_line_reg;
    logic       out_valid_reg;
    logic       fire;

    owtsm_cfg u_cfg
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .cfg_addr (cfg_addr),
        .cfg_data (cfg_data),
        .cfg      (cfg)
    );

    owtsm_step
    #(
        .SCRATCHPAD_BYTES (SCRATCHPAD_BYTES)
    )
    u_step
    (
        .st         (state_reg),
        .cfg        (cfg),
        .req_type   (in_req_reg),
        .line_level (in_line_reg),
        .st_next    (state_next),
        .res        (step_res)
    );

    // Advance a held item when the result register is free or being drained
    assign fire     = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || fire;

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
        begin
            in_req_reg  <= s_tuser;
            in_line_reg <= s_tdata[0];
        end
    end

    // Sequencer state, updated once per processed item
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= '0;
        end
        else if (fire)
        begin
            state_reg <= state_next;
        end
    end

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (fire)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            out_res_reg <= step_res;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {3'b000, out_res_reg};

endmodule

// ===== tb/one_wire_temp_sensor_master_checker.sv =====
// Result checker for the one-wire temperature sensor master: watches the tick, result and
// configuration channels, predicts every result item and compares it field by field.
// Depends on owtsm_pkg.
module one_wire_temp_sensor_master_checker
    import owtsm_pkg::*;
#(
    parameter int PAD_BYTES = 9
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    input  logic                  s_tready,
    input  logic [7:0]            s_tdata,   // [0] line_level, [7:1] zero
    input  logic [1:0]            s_tuser,   // [1:0] req_type
    input  logic                  m_tvalid,
    input  logic                  m_tready,
    // [0] drive_low, [1] busy_res, [2] done_res, [18:3] temperature,
    // [19] crc_ok, [20] rejected, [23:21] zero
    input  logic [23:0]           m_tdata,
    input  logic                  cfg_we,
    input  logic [2:0]            cfg_addr,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output int                    mismatches,
    output int                    outstanding
);

    // 0x18 reflected into the right-shifting register, feedback bit included
    localparam logic [7:0] CRC_FOLD = 8'h8C;

    // Timing and write-byte settings as last written
    logic [9:0]  rst_len;
    logic [3:0]  open_len;
    logic [7:0]  wslot_len;
    logic [5:0]  sample_len;
    logic [7:0]  tail_len;
    logic [7:0]  alarm_hi;
    logic [7:0]  alarm_lo;
    logic [7:0]  res_cfg;

    // Sequencer state of the bus master
    logic [3:0]  seq_step;
    logic [1:0]  run_cmd;
    logic [2:0]  slot_ph;
    logic [9:0]  tick_cnt;
    logic [2:0]  bit_no;
    logic [3:0]  byte_no;
    logic [7:0]  shreg;
    logic [7:0]  crc_acc;
    logic [7:0]  temp_lo;
    logic [7:0]  temp_hi;
    logic [15:0] temp_held;
    logic        crc_good;

    owtsm_res_t  tick_results_due[$];
    owtsm_res_t  want;

    // Count one tick of the current phase; report when the phase has run its length
    function automatic bit span_elapsed(input int unsigned limit);
        int unsigned span;
        span = (limit == 0) ? 1 : limit;
        tick_cnt = tick_cnt + 10'd1;
        if (tick_cnt >= span)
        begin
            tick_cnt = '0;
            return 1'b1;
        end
        return 1'b0;
    endfunction

    // Byte to put on the bus for the current write position
    function automatic logic [7:0] cmd_byte();
        case (byte_no)
            4'd0: return ROM_SKIP;
            4'd1: return (run_cmd == REQ_CONVERT) ? FN_CONVERT :
                         ((run_cmd == REQ_SET_RES) ? FN_WRITE_PAD : FN_READ_PAD);
            4'd2: return alarm_hi;
            4'd3: return alarm_lo;
            default: return res_cfg;
        endcase
    endfunction

    function automatic void end_sequence();
        seq_step = STEP_IDLE;
        slot_ph  = PHASE_OPEN;
        tick_cnt = '0;
        bit_no   = '0;
        byte_no  = '0;
    endfunction

    // Advance the bus master by one tick and give the result item for it
    function automatic owtsm_res_t advance_bus_master(input logic [1:0] req, input logic line);
        owtsm_res_t r;
        logic       drv;
        logic       fin;
        logic       rej;
        logic       fb;
        logic [7:0] din;
        drv = 1'b0;
        fin = 1'b0;
        rej = 1'b0;

        // Take a command only while idle, flag it otherwise
        if (req != REQ_NONE)
        begin
            if (seq_step != STEP_IDLE)
            begin
                rej = 1'b1;
            end
            else
            begin
                run_cmd  = req;
                seq_step = STEP_RST_LOW;
                slot_ph  = PHASE_OPEN;
                tick_cnt = '0;
                bit_no   = '0;
                byte_no  = '0;
                shreg    = '0;
                crc_acc  = '0;
            end
        end

        case (seq_step)
            STEP_IDLE:
            begin
            end
            STEP_RST_LOW:
            begin
                drv = 1'b1;
                if (span_elapsed(rst_len))
                begin
                    seq_step = STEP_RST_WAIT;
                end
            end
            STEP_RST_WAIT:
            begin
                if (span_elapsed(rst_len))
                begin
                    seq_step = STEP_WRITE;
                    slot_ph  = PHASE_OPEN;
                    bit_no   = '0;
                    byte_no  = '0;
                    shreg    = cmd_byte();
                end
            end
            STEP_WRITE:
            begin
                case (slot_ph)
                    PHASE_OPEN:
                    begin
                        drv = 1'b1;
                        if (span_elapsed(open_len))
                        begin
                            slot_ph = PHASE_MID;
                        end
                    end
                    PHASE_MID:
                    begin
                        drv = ~shreg[0];
                        if (span_elapsed(wslot_len))
                        begin
                            slot_ph = PHASE_TAIL;
                        end
                    end
                    default:
                    begin
                        // Recovery done: move to the next bit, byte or step
                        if (span_elapsed(open_len))
                        begin
                            slot_ph = PHASE_OPEN;
                            shreg   = {1'b0, shreg[7:1]};
                            if (bit_no < 3'd7)
                            begin
                                bit_no = bit_no + 3'd1;
                            end
                            else
                            begin
                                bit_no  = '0;
                                byte_no = byte_no + 4'd1;
                                if (byte_no >= ((run_cmd == REQ_SET_RES) ? WR_COUNT_SET_RES
                                                                         : WR_COUNT_SHORT))
                                begin
                                    if (run_cmd == REQ_READ)
                                    begin
                                        seq_step = STEP_READ;
                                        byte_no  = '0;
                                        shreg    = '0;
                                        crc_acc  = '0;
                                    end
                                    else
                                    begin
                                        end_sequence();
                                        fin = 1'b1;
                                    end
                                end
                                else
                                begin
                                    shreg = cmd_byte();
                                end
                            end
                        end
                    end
                endcase
            end
            STEP_READ:
            begin
                case (slot_ph)
                    PHASE_OPEN:
                    begin
                        drv = 1'b1;
                        if (span_elapsed(open_len))
                        begin
                            slot_ph = PHASE_MID;
                        end
                    end
                    PHASE_MID:
                    begin
                        // Sample the line on the last released tick
                        if (span_elapsed(sample_len))
                        begin
                            shreg   = {line, shreg[7:1]};
                            slot_ph = PHASE_TAIL;
                        end
                    end
                    default:
                    begin
                        if (span_elapsed(tail_len))
                        begin
                            slot_ph = PHASE_OPEN;
                            if (bit_no < 3'd7)
                            begin
                                bit_no = bit_no + 3'd1;
                            end
                            else
                            begin
                                bit_no = '0;
                                // Fold the finished byte into the CRC, low bit first
                                din = shreg;
                                for (int k = 0; k < 8; k++)
                                begin
                                    fb      = crc_acc[0] ^ din[0];
                                    crc_acc = (crc_acc >> 1) ^ (fb ? CRC_FOLD : 8'h00);
                                    din     = din >> 1;
                                end
                                if (byte_no == 4'd0)
                                begin
                                    temp_lo = shreg;
                                end
                                if (byte_no == 4'd1)
                                begin
                                    temp_hi = shreg;
                                end
                                if (byte_no >= PAD_BYTES - 1)
                                begin
                                    if (crc_acc == 8'h00)
                                    begin
                                        temp_held = {temp_hi, temp_lo};
                                        crc_good  = 1'b1;
                                    end
                                    else
                                    begin
                                        temp_held = '0;
                                        crc_good  = 1'b0;
                                    end
                                    end_sequence();
                                    fin = 1'b1;
                                end
                                else
                                begin
                                    byte_no = byte_no + 4'd1;
                                    shreg   = '0;
                                end
                            end
                        end
                    end
                endcase
            end
            default:
            begin
                end_sequence();
            end
        endcase

        r.drive_low   = drv;
        r.busy_res    = (seq_step != STEP_IDLE);
        r.done_res    = fin;
        r.temperature = temp_held;
        r.crc_ok      = crc_good;
        r.rejected    = rej;
        return r;
    endfunction

    task automatic match_field(input string label, input int want_v, input int got_v);
        if (want_v != got_v)
        begin
            mismatches++;
            $display("%0t: %s expected %0d actual %0d", $time, label, want_v, got_v);
        end
    endtask

    // Track configuration, predict on every accepted tick, check every result item
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rst_len    = RST_RESET_TICKS;
            open_len   = RST_START_TICKS;
            wslot_len  = RST_WRITE_SLOT;
            sample_len = RST_READ_SAMPLE;
            tail_len   = RST_READ_TAIL;
            alarm_hi   = '0;
            alarm_lo   = '0;
            res_cfg    = RST_RESOLUTION;
            seq_step   = STEP_IDLE;
            run_cmd    = REQ_NONE;
            slot_ph    = PHASE_OPEN;
            tick_cnt   = '0;
            bit_no     = '0;
            byte_no    = '0;
            shreg      = '0;
            crc_acc    = '0;
            temp_lo    = '0;
            temp_hi    = '0;
            temp_held  = '0;
            crc_good   = 1'b0;
            tick_results_due.delete();
            mismatches  = 0;
            outstanding = 0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_addr)
                    CFG_RESET_TICKS: rst_len    = cfg_data[9:0];
                    CFG_START_TICKS: open_len   = cfg_data[3:0];
                    CFG_WRITE_SLOT:  wslot_len  = cfg_data[7:0];
                    CFG_READ_SAMPLE: sample_len = cfg_data[5:0];
                    CFG_READ_TAIL:   tail_len   = cfg_data[7:0];
                    CFG_ALARM_HIGH:  alarm_hi   = cfg_data[7:0];
                    CFG_ALARM_LOW:   alarm_lo   = cfg_data[7:0];
                    CFG_RESOLUTION:  res_cfg    = cfg_data[7:0];
                    default:
                    begin
                    end
                endcase
            end

            // Compare before predicting so a stray result never meets this cycle's item
            if (m_tvalid && m_tready)
            begin
                if (tick_results_due.size() == 0)
                begin
                    mismatches++;
                    $display("%0t: result item with none expected, actual %h", $time, m_tdata);
                end
                else
                begin
                    want = tick_results_due.pop_front();
                    match_field("drive_low", want.drive_low, m_tdata[0]);
                    match_field("busy_res", want.busy_res, m_tdata[1]);
                    match_field("done_res", want.done_res, m_tdata[2]);
                    match_field("temperature", int'($signed(want.temperature)),
                                int'($signed(m_tdata[18:3])));
                    match_field("crc_ok", want.crc_ok, m_tdata[19]);
                    match_field("rejected", want.rejected, m_tdata[20]);
                end
            end

            if (s_tvalid && s_tready)
            begin
                tick_results_due.push_back(advance_bus_master(s_tuser, s_tdata[0]));
            end

            outstanding = tick_results_due.size();
        end
    end

endmodule

// ===== tb/one_wire_temp_sensor_master_top_tb.sv =====
// Testbench top for the one-wire temperature sensor master: clock, reset, tick stimulus,
// result back-pressure, configuration phases and the final verdict.
// Depends on owtsm_pkg, the block and one_wire_temp_sensor_master_checker.
module one_wire_temp_sensor_master_top_tb;
    import owtsm_pkg::*;

    localparam int PAD_BYTES    = 9;
    localparam int STALL_CYCLES = 300;
    // Bounds the run with a wide margin over all ticks under the heaviest idling, plus
    // drains and the long stall
    localparam int CLK_LIMIT    = 100000;
    localparam logic [7:0] CRC_FOLD = 8'h8C;

    logic                  clk;
    logic                  rst_n;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [7:0]            s_tdata;   // [0] line_level, [7:1] zero
    logic [1:0]            s_tuser;   // [1:0] req_type
    logic                  m_tvalid;
    logic                  m_tready;
    // [0] drive_low, [1] busy_res, [2] done_res, [18:3] temperature,
    // [19] crc_ok, [20] rejected, [23:21] zero
    logic [23:0]           m_tdata;
    logic                  cfg_we;
    logic [2:0]            cfg_addr;
    logic [CFG_DATA_W-1:0] cfg_data;

    int mismatches;
    int outstanding;
    int tx_idle_pct;
    int rx_idle_pct;
    bit stall_req;
    bit stall_done;
    int busy_left;
    int items_sent;
    int cycles;

    // Phase lengths as the block sees them, zero counting as one tick
    int unsigned len_reset  = RST_RESET_TICKS;
    int unsigned len_open   = RST_START_TICKS;
    int unsigned len_wslot  = RST_WRITE_SLOT;
    int unsigned len_sample = RST_READ_SAMPLE;
    int unsigned len_tail   = RST_READ_TAIL;

    one_wire_temp_sensor_master_top
    #(
        .SCRATCHPAD_BYTES(PAD_BYTES)
    )
    dut
    (
        .clk(clk),
        .rst_n(rst_n),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata(s_tdata),
        .s_tuser(s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata(m_tdata),
        .cfg_we(cfg_we),
        .cfg_addr(cfg_addr),
        .cfg_data(cfg_data)
    );

    one_wire_temp_sensor_master_checker
    #(
        .PAD_BYTES(PAD_BYTES)
    )
    watch
    (
        .clk(clk),
        .rst_n(rst_n),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata(s_tdata),
        .s_tuser(s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata(m_tdata),
        .cfg_we(cfg_we),
        .cfg_addr(cfg_addr),
        .cfg_data(cfg_data),
        .mismatches(mismatches),
        .outstanding(outstanding)
    );

    always
    begin
        clk = 1'b0;
        #6;
        clk = 1'b1;
        #6;
    end

    // Abort a hung run
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CLK_LIMIT)
        begin
            $display("Some tests failed");
            $finish;
        end
    end

    // Result side: random back-pressure, or one long hold-off when asked
    initial
    begin
        m_tready   = 1'b0;
        stall_done = 1'b0;
        forever
        begin
            @(negedge clk);
            if (stall_req && !stall_done)
            begin
                m_tready <= 1'b0;
                repeat (STALL_CYCLES - 1) @(negedge clk);
                stall_done = 1'b1;
            end
            else
            begin
                m_tready <= ($urandom_range(0, 99) >= rx_idle_pct);
            end
        end
    end

    // Ticks a command keeps the sequencer busy, the command tick included
    function automatic int seq_ticks(input logic [1:0] req);
        int total;
        total = 2 * len_reset + 8 * ((req == REQ_SET_RES) ? WR_COUNT_SET_RES : WR_COUNT_SHORT)
                * (2 * len_open + len_wslot);
        if (req == REQ_READ)
        begin
            total += 8 * PAD_BYTES * (len_open + len_sample + len_tail);
        end
        return total;
    endfunction

    // Mostly no command, now and then a stray one
    function automatic logic [1:0] stray_req();
        if ($urandom_range(0, 15) == 0)
        begin
            return 2'($urandom_range(1, 3));
        end
        return REQ_NONE;
    endfunction

    // Offer one tick item at a falling edge and hold it until it is taken
    task automatic tick_item(input logic [1:0] req, input logic line);
        while ($urandom_range(0, 99) < tx_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= req;
        s_tdata  <= {7'd0, line};
        @(posedge clk);
        while (!s_tready) @(posedge clk);
        @(negedge clk);
        if (req != REQ_NONE && busy_left == 0)
        begin
            busy_left = seq_ticks(req);
        end
        if (busy_left > 0)
        begin
            busy_left--;
        end
        items_sent++;
    endtask

    // Let the sequencer run out and every result item drain
    task automatic settle();
        while (busy_left > 0) tick_item(REQ_NONE, 1'($urandom_range(0, 1)));
        s_tvalid <= 1'b0;
        while (outstanding != 0) @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    // One register write; bits above the register width carry junk half the time
    task automatic write_reg(input logic [2:0] idx, input int unsigned val);
        logic [CFG_DATA_W-1:0] word;
        int unsigned           keep;
        int unsigned           eff;
        keep = (idx == CFG_RESET_TICKS) ? 10 : (idx == CFG_START_TICKS) ? 4 :
               (idx == CFG_READ_SAMPLE) ? 6 : 8;
        word = $urandom_range(0, 1) ? CFG_DATA_W'($urandom) : '0;
        for (int b = 0; b < CFG_DATA_W; b++)
        begin
            if (b < keep)
            begin
                word[b] = val[b];
            end
        end
        eff = val & ((1 << keep) - 1);
        eff = (eff == 0) ? 1 : eff;
        case (idx)
            CFG_RESET_TICKS: len_reset  = eff;
            CFG_START_TICKS: len_open   = eff;
            CFG_WRITE_SLOT:  len_wslot  = eff;
            CFG_READ_SAMPLE: len_sample = eff;
            CFG_READ_TAIL:   len_tail   = eff;
            default:
            begin
            end
        endcase
        cfg_we   <= 1'b1;
        cfg_addr <= idx;
        cfg_data <= word;
        @(negedge clk);
    endtask

    task automatic configure(input int unsigned r, input int unsigned s, input int unsigned w,
                             input int unsigned p, input int unsigned t, input int unsigned ah,
                             input int unsigned al, input int unsigned rb);
        settle();
        write_reg(CFG_RESET_TICKS, r);
        write_reg(CFG_START_TICKS, s);
        write_reg(CFG_WRITE_SLOT, w);
        write_reg(CFG_READ_SAMPLE, p);
        write_reg(CFG_READ_TAIL, t);
        write_reg(CFG_ALARM_HIGH, ah);
        write_reg(CFG_ALARM_LOW, al);
        write_reg(CFG_RESOLUTION, rb);
        cfg_we <= 1'b0;
        @(negedge clk);
    endtask

    // Run one whole command; for a read, answer every sample with a scratchpad bit
    task automatic run_sequence(input logic [1:0] req, input bit good);
        logic [7:0] pad [PAD_BYTES];
        logic [7:0] crc;
        logic [7:0] din;
        logic       fb;
        logic       line;
        int         total;
        int         base;
        int         slot;
        int         k;
        while (busy_left > 0) tick_item(stray_req(), 1'($urandom_range(0, 1)));

        // Random scratchpad, sometimes with an extreme temperature, sealed by its CRC
        for (int i = 0; i < PAD_BYTES; i++)
        begin
            pad[i] = 8'($urandom_range(0, 255));
        end
        case ($urandom_range(0, 7))
            0: {pad[1], pad[0]} = 16'h8000;
            1: {pad[1], pad[0]} = 16'h7FFF;
            2: {pad[1], pad[0]} = 16'hFFFF;
            3: {pad[1], pad[0]} = 16'h0000;
            default:
            begin
            end
        endcase
        crc = '0;
        for (int i = 0; i < PAD_BYTES - 1; i++)
        begin
            din = pad[i];
            for (int b = 0; b < 8; b++)
            begin
                fb  = crc[0] ^ din[0];
                crc = (crc >> 1) ^ (fb ? CRC_FOLD : 8'h00);
                din = din >> 1;
            end
        end
        pad[PAD_BYTES - 1] = crc;
        // Break the frame with one flipped bit
        if (!good)
        begin
            k = $urandom_range(0, PAD_BYTES * 8 - 1);
            pad[k / 8][k % 8] = ~pad[k / 8][k % 8];
        end

        total = seq_ticks(req);
        base  = seq_ticks(REQ_CONVERT);
        slot  = len_open + len_sample + len_tail;
        tick_item(req, 1'($urandom_range(0, 1)));
        for (int pos = 1; pos < total; pos++)
        begin
            line = 1'($urandom_range(0, 1));
            if (req == REQ_READ && pos >= base && (pos - base) % slot == len_open + len_sample - 1)
            begin
                k    = (pos - base) / slot;
                line = pad[k / 8][k % 8];
            end
            tick_item(stray_req(), line);
        end
    endtask

    // Mostly whole commands with random content, the rest loose ticks and commands
    task automatic run_random(input int count);
        int first;
        int pick;
        first = items_sent;
        while (items_sent - first < count)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 45)
            begin
                run_sequence(REQ_READ, pick < 36);
            end
            else if (pick < 60)
            begin
                run_sequence(REQ_CONVERT, 1'b1);
            end
            else if (pick < 75)
            begin
                run_sequence(REQ_SET_RES, 1'b1);
            end
            else
            begin
                repeat ($urandom_range(1, 8))
                begin
                    tick_item(($urandom_range(0, 3) == 0) ? 2'($urandom_range(1, 3)) : REQ_NONE,
                              1'($urandom_range(0, 1)));
                end
            end
        end
    endtask

    initial
    begin
        rst_n       = 1'b0;
        s_tvalid    = 1'b0;
        s_tdata     = '0;
        s_tuser     = REQ_NONE;
        cfg_we      = 1'b0;
        cfg_addr    = CFG_RESET_TICKS;
        cfg_data    = '0;
        stall_req   = 1'b0;
        busy_left   = 0;
        items_sent  = 0;
        tx_idle_pct = 12;
        rx_idle_pct = 57;
        repeat (11) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed: zero-length timings, ticks at both line levels, a command with
        // commands piling in behind it, then set resolution and a read with a broken frame
        configure(0, 0, 0, 0, 0, 8'hFF, 8'h00, 8'h80);
        tick_item(REQ_NONE, 1'b0);
        tick_item(REQ_NONE, 1'b1);
        tick_item(REQ_CONVERT, 1'b1);
        tick_item(REQ_SET_RES, 1'b0);
        tick_item(REQ_READ, 1'b1);
        tick_item(REQ_CONVERT, 1'b0);
        run_sequence(REQ_SET_RES, 1'b1);
        run_sequence(REQ_READ, 1'b0);

        // Shortest timings, light sender gaps, heavy result stalls
        configure(1, 1, 1, 1, 1, $urandom_range(0, 255), $urandom_range(0, 255),
                  $urandom_range(0, 255));
        run_random(150);

        // Small random timings, heavy sender gaps, light result stalls
        tx_idle_pct = 57;
        rx_idle_pct = 12;
        configure($urandom_range(1, 4), $urandom_range(1, 2), $urandom_range(1, 3),
                  $urandom_range(1, 2), $urandom_range(1, 2), $urandom_range(0, 255),
                  $urandom_range(0, 255), $urandom_range(0, 255));
        run_random(100);

        // Short timings, no idling, with the result side held off while ticks keep coming
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        configure($urandom_range(1, 2), $urandom_range(1, 2), $urandom_range(1, 2),
                  $urandom_range(1, 2), $urandom_range(1, 2), $urandom_range(0, 255),
                  $urandom_range(0, 255), $urandom_range(0, 255));
        stall_req = 1'b1;
        run_random(100);

        s_tvalid <= 1'b0;
        while (outstanding != 0) @(negedge clk);
        repeat (8) @(negedge clk);
        if (mismatches == 0)
        begin
            $display("All tests passed");
        end
        else
        begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

// ===== one_wire_temp_sensor_master_top.f =====
hw/rtl/owtsm_pkg.sv
hw/rtl/owtsm_cfg.sv
hw/rtl/owtsm_step.sv
hw/rtl/one_wire_temp_sensor_master_top.sv
tb/one_wire_temp_sensor_master_checker.sv
tb/one_wire_temp_sensor_master_top_tb.sv
